/* sv/warp_lop3_lea_execute_defines.svh */
// Assertion macros shared by the execute block.
`ifndef WARP_LOP3_LEA_EXECUTE_DEFINES_SVH
`define WARP_LOP3_LEA_EXECUTE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define WLLE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("execute block invariant violated");
// Check that cons holds in the cycle after ante.
`define WLLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("execute block sequencing violated");
`else
`define WLLE_ASSERT_IMP(label, clk, rst, ante, cons)
`define WLLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/wlle_pkg.sv */
package wlle_pkg;

   // Default sizes of the warp
   localparam int LANES_DEFAULT      = 32;
   localparam int REGISTERS_DEFAULT  = 256;
   localparam int PREDICATES_DEFAULT = 8;

   localparam int WORD_W = 32;

   // Special operand codes
   localparam logic [7:0] NO_HIGH_WORD  = 8'd255;
   localparam logic [2:0] NO_PRED_WRITE = 3'd7;
   localparam logic [4:0] SHIFT_MAX     = 5'd31;

   typedef enum logic [1:0] {
      CMD_LOP3       = 2'd0,
      CMD_LEA        = 2'd1,
      CMD_WRITE_REG  = 2'd2,
      CMD_WRITE_PRED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  dest_reg;
      logic [7:0]  src_a_reg;
      logic [7:0]  src_b_reg;
      logic [7:0]  src_c_reg;
      logic [7:0]  lut_or_shift;
      logic        high_mode;
      logic        extended;
      logic [2:0]  pred_dest;
      logic [2:0]  pred_src;
      logic [4:0]  lane;
      logic [31:0] write_data;
   } wlle_req_type;

   typedef struct packed {
      logic [4:0]  lane_index;
      logic [31:0] result_value;
      logic        carry_out;
      logic        carry_written;
      logic        last;
   } wlle_rsp_type;

   // Operation controls handed to the lane ALU
   typedef struct packed {
      logic [7:0] lut;
      logic [4:0] shift;
      logic       high_mode;
      logic       no_high;
   } alu_ctrl_type;

   // Index width for a table of n entries, at least one bit
   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // Reduce an 8-bit index modulo a small constant by restoring subtraction
   function automatic logic [7:0] mod_reduce(input logic [7:0] value,
                                             input int unsigned modulus);
      logic [15:0] rem;
      logic [15:0] step;
      rem = {8'd0, value};
      for (int k = 7; k >= 0; k--) begin
         step = 16'(modulus << k);
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[7:0];
   endfunction

endpackage

/* sv/wlle_ram.sv */
module wlle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/wlle_pred_file.sv */
module wlle_pred_file #(
   parameter int LANES      = wlle_pkg::LANES_DEFAULT,
   parameter int PREDICATES = wlle_pkg::PREDICATES_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     wr_en,
   input  logic [wlle_pkg::idx_width(PREDICATES)-1:0] wr_row,
   input  logic [wlle_pkg::idx_width(LANES)-1:0]    wr_lane,
   input  logic                                     wr_bit,
   input  logic [wlle_pkg::idx_width(PREDICATES)-1:0] rd_row,
   input  logic [wlle_pkg::idx_width(LANES)-1:0]    rd_lane,
   output logic                                     rd_bit
);

   import wlle_pkg::*;

   logic [PREDICATES-1:0][LANES-1:0] pred_ff;

   // Clear all predicates at reset, update one lane bit per write
   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff <= '0;
      end else if (wr_en) begin
         pred_ff[wr_row][wr_lane] <= wr_bit;
      end
   end

   assign rd_bit = pred_ff[rd_row][rd_lane];

endmodule

/* sv/wlle_alu.sv */
module wlle_alu (
   input  logic                   [31:0] src_a,
   input  logic                   [31:0] src_b,
   input  logic                   [31:0] src_c,
   input  wlle_pkg::alu_ctrl_type        ctrl,
   output logic                   [31:0] lop_value,
   output logic                   [32:0] shift_value
);

   import wlle_pkg::*;

   logic [31:0] high_word;
   logic [63:0] pair;
   logic [5:0]  right_amount;
   logic [63:0] right_pair;
   logic [32:0] left_pair;

   // Look up each bit position in the truth table
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         lop_value[i] = ctrl.lut[{src_a[i], src_b[i], src_c[i]}];
      end
   end

   // Build the high:low pair; only bit 32 of a left shift survives above the word
   assign high_word    = ctrl.no_high ? '0 : src_c;
   assign pair         = {high_word, src_a};
   assign right_amount = 6'd32 - {1'b0, ctrl.shift};
   assign right_pair   = pair >> right_amount;
   assign left_pair    = {high_word[0], src_a} << ctrl.shift;

   assign shift_value = ctrl.high_mode ? right_pair[32:0] : left_pair;

endmodule

/* sv/warp_lop3_lea_execute.sv */
// LOP3/LEA execute: one lane result per cycle unless rsp_stall holds it, lane 0 first,
// LANES results per instruction. After accept the block enters the issue state; each lane
// is then registered in s1 (register file read), s2 and the output register. No new
// instruction is taken until the last one drains; register and predicate writes give no result.
// Reset clears the predicates and control state; register contents stay undefined
// until written.
`include "warp_lop3_lea_execute_defines.svh"

module warp_lop3_lea_execute #(
   parameter int LANES      = wlle_pkg::LANES_DEFAULT,
   parameter int REGISTERS  = wlle_pkg::REGISTERS_DEFAULT,
   parameter int PREDICATES = wlle_pkg::PREDICATES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wlle_pkg::wlle_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wlle_pkg::wlle_rsp_type rsp_data
);

   import wlle_pkg::*;

   localparam int LANE_W = idx_width(LANES);
   localparam int RIDX_W = idx_width(REGISTERS);
   localparam int PIDX_W = idx_width(PREDICATES);
   localparam int RF_AW  = RIDX_W + LANE_W;
   localparam int RF_DEPTH = 1 << RF_AW;
   localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

   state_type state_ff, state_in;

   logic req_accept;
   logic advance;
   logic issue;
   logic commit;
   logic is_exec;
   logic lane_ok;

   // Instruction fields held for the whole pass over the lanes
   cmd_type           cmd_ff;
   logic [RIDX_W-1:0] rd_idx_ff;
   logic [RIDX_W-1:0] ra_idx_ff;
   logic [RIDX_W-1:0] rb_idx_ff;
   logic [RIDX_W-1:0] rc_idx_ff;
   alu_ctrl_type      alu_ctrl_ff;
   logic              ext_ff;
   logic [PIDX_W-1:0] pd_idx_ff;
   logic              pd_none_ff;
   logic [PIDX_W-1:0] ps_idx_ff;

   logic [LANE_W-1:0] lane_ff, lane_in;

   logic              s1_valid_ff;
   logic [LANE_W-1:0] s1_lane_ff;

   logic              s2_valid_ff;
   logic [LANE_W-1:0] s2_lane_ff;
   logic [31:0]       s2_lop_ff;
   logic [32:0]       s2_shift_ff;
   logic [31:0]       s2_b_ff;
   logic              s2_cin_ff;

   logic         rsp_valid_ff;
   wlle_rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0] bank_a_data;
   logic [31:0] bank_b_data;
   logic [31:0] bank_c_data;
   logic [31:0] lop_value;
   logic [32:0] shift_value;
   logic        pred_rd_bit;

   logic             rf_wr_en;
   logic [RF_AW-1:0] rf_wr_addr;
   logic [31:0]      rf_wr_data;

   logic              pf_wr_en;
   logic [PIDX_W-1:0] pf_wr_row;
   logic [LANE_W-1:0] pf_wr_lane;
   logic              pf_wr_bit;

   logic        is_lea;
   logic [32:0] sum;
   logic [31:0] result;
   logic        carry;

   assign req_accept = req_valid && !req_stall;
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign commit     = advance && s2_valid_ff;
   assign is_exec    = (req_data.command == CMD_LOP3) || (req_data.command == CMD_LEA);
   assign lane_ok    = 7'(req_data.lane) < 7'(LANES);

   // Sequence the lanes: accept, issue one lane per cycle unless the output stalls, drain the pipeline
   always_comb begin
      state_in  = state_ff;
      issue     = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_exec) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (advance) begin
               issue = 1'b1;
               if (lane_ff == LAST_LANE) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && (!s2_valid_ff || advance)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Restart the lane counter on accept, advance it on each issue
   always_comb begin
      lane_in = lane_ff;
      if (req_accept) begin
         lane_in = '0;
      end else if (issue) begin
         lane_in = lane_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   // Capture the instruction with reduced indexes and clamped shift
   always_ff @(posedge clock) begin
      if (req_accept && is_exec) begin
         cmd_ff                <= req_data.command;
         rd_idx_ff             <= RIDX_W'(mod_reduce(req_data.dest_reg, REGISTERS));
         ra_idx_ff             <= RIDX_W'(mod_reduce(req_data.src_a_reg, REGISTERS));
         rb_idx_ff             <= RIDX_W'(mod_reduce(req_data.src_b_reg, REGISTERS));
         rc_idx_ff             <= RIDX_W'(mod_reduce(req_data.src_c_reg, REGISTERS));
         alu_ctrl_ff.lut       <= req_data.lut_or_shift;
         alu_ctrl_ff.shift     <= (req_data.lut_or_shift > 8'(SHIFT_MAX)) ?
                                  SHIFT_MAX : req_data.lut_or_shift[4:0];
         alu_ctrl_ff.high_mode <= req_data.high_mode;
         alu_ctrl_ff.no_high   <= (req_data.src_c_reg == NO_HIGH_WORD);
         ext_ff                <= req_data.extended;
         pd_idx_ff             <= PIDX_W'(mod_reduce({5'd0, req_data.pred_dest}, PREDICATES));
         pd_none_ff            <= (req_data.pred_dest == NO_PRED_WRITE);
         ps_idx_ff             <= PIDX_W'(mod_reduce({5'd0, req_data.pred_src}, PREDICATES));
      end
   end

   // Register file write port: lane commit or a register write transaction
   always_comb begin
      if (commit) begin
         rf_wr_en   = 1'b1;
         rf_wr_addr = {rd_idx_ff, s2_lane_ff};
         rf_wr_data = result;
      end else begin
         rf_wr_en   = req_accept && (req_data.command == CMD_WRITE_REG) && lane_ok;
         rf_wr_addr = {RIDX_W'(mod_reduce(req_data.dest_reg, REGISTERS)),
                       LANE_W'(req_data.lane)};
         rf_wr_data = req_data.write_data;
      end
   end

   // Keep the register file in three copies, one per source operand
   wlle_ram #(.WIDTH(WORD_W), .DEPTH(RF_DEPTH)) u_bank_a (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_addr),
      .wr_data (rf_wr_data),
      .rd_en   (issue),
      .rd_addr ({ra_idx_ff, lane_ff}),
      .rd_data (bank_a_data)
   );

   wlle_ram #(.WIDTH(WORD_W), .DEPTH(RF_DEPTH)) u_bank_b (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_addr),
      .wr_data (rf_wr_data),
      .rd_en   (issue),
      .rd_addr ({rb_idx_ff, lane_ff}),
      .rd_data (bank_b_data)
   );

   wlle_ram #(.WIDTH(WORD_W), .DEPTH(RF_DEPTH)) u_bank_c (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_addr),
      .wr_data (rf_wr_data),
      .rd_en   (issue),
      .rd_addr ({rc_idx_ff, lane_ff}),
      .rd_data (bank_c_data)
   );

   // Predicate write port: lea carry on commit or a predicate write transaction
   always_comb begin
      if (commit) begin
         pf_wr_en   = is_lea && !pd_none_ff;
         pf_wr_row  = pd_idx_ff;
         pf_wr_lane = s2_lane_ff;
         pf_wr_bit  = carry;
      end else begin
         pf_wr_en   = req_accept && (req_data.command == CMD_WRITE_PRED) && lane_ok;
         pf_wr_row  = PIDX_W'(mod_reduce({5'd0, req_data.pred_dest}, PREDICATES));
         pf_wr_lane = LANE_W'(req_data.lane);
         pf_wr_bit  = req_data.write_data[0];
      end
   end

   wlle_pred_file #(.LANES(LANES), .PREDICATES(PREDICATES)) u_pred_file (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (pf_wr_en),
      .wr_row  (pf_wr_row),
      .wr_lane (pf_wr_lane),
      .wr_bit  (pf_wr_bit),
      .rd_row  (ps_idx_ff),
      .rd_lane (s1_lane_ff),
      .rd_bit  (pred_rd_bit)
   );

   wlle_alu u_alu (
      .src_a       (bank_a_data),
      .src_b       (bank_b_data),
      .src_c       (bank_c_data),
      .ctrl        (alu_ctrl_ff),
      .lop_value   (lop_value),
      .shift_value (shift_value)
   );

   // Advance the lane pipeline valids together; hold everything on output stall
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_lane_ff  <= lane_ff;
         s2_lane_ff  <= s1_lane_ff;
         s2_lop_ff   <= lop_value;
         s2_shift_ff <= shift_value;
         s2_b_ff     <= bank_b_data;
         s2_cin_ff   <= ext_ff && pred_rd_bit;
      end
   end

   // Finish the lane: add the addend and carry in, pick the operation's result
   assign is_lea = (cmd_ff == CMD_LEA);
   assign sum    = s2_shift_ff + {1'b0, s2_b_ff} + {32'd0, s2_cin_ff};
   assign result = is_lea ? sum[31:0] : s2_lop_ff;
   assign carry  = is_lea && sum[32];

   always_comb begin
      rsp_data_in.lane_index    = 5'(s2_lane_ff);
      rsp_data_in.result_value  = result;
      rsp_data_in.carry_out     = carry;
      rsp_data_in.carry_written = is_lea && !pd_none_ff;
      rsp_data_in.last          = (s2_lane_ff == LAST_LANE);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `WLLE_ASSERT_IMP(a_accept_pipe_empty, clock, reset, req_accept, !s1_valid_ff && !s2_valid_ff)
   `WLLE_ASSERT_IMP(a_lane_order, clock, reset, s1_valid_ff && s2_valid_ff, s1_lane_ff == s2_lane_ff + 1'b1)
   `WLLE_ASSERT_IMP(a_write_port_free, clock, reset, commit, !req_accept)
   `WLLE_ASSERT_NEXT(a_issue_fills_s1, clock, reset, issue, s1_valid_ff)

endmodule
